// File: sv/mtf_pkg.sv
// Shared types and constants for the move-to-front list core.
package mtf_pkg;

  localparam int unsigned MTF_DEPTH   = 16;
  localparam int unsigned MTF_DATA_W  = 32;
  localparam int unsigned MTF_POS_W   = 8;
  localparam int unsigned MTF_POS_OUT = 4;
  localparam int unsigned MTF_CNT_OUT = 5;

  typedef struct packed {
    logic                 hit;
    logic [MTF_POS_W-1:0] pos;
  } chain_t;

  typedef struct packed {
    logic clr;
    logic ld;
  } cell_ctl_t;

endpackage

// File: sv/mtf_cell.sv
// One list cell: holds an entry, compares it against the key, passes the match token on.
module mtf_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mtf_pkg::cell_ctl_t               ctl,
  input  logic [mtf_pkg::MTF_DATA_W-1:0]   d_in,
  input  logic [mtf_pkg::MTF_DATA_W-1:0]   key,
  input  logic                             vld,
  input  mtf_pkg::chain_t                  chain_in,
  output mtf_pkg::chain_t                  chain_out,
  output logic [mtf_pkg::MTF_DATA_W-1:0]   entry,
  output logic                             pre
);

  logic [mtf_pkg::MTF_DATA_W-1:0] entry_r;
  mtf_pkg::chain_t                chain_r;
  logic                           match;

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      entry_r <= d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r <= '0;
    end else if (ctl.clr) begin
      chain_r <= '0;
    end else begin
      chain_r <= chain_in;
    end
  end

  assign match         = vld && (entry_r == key);
  assign chain_out.hit = chain_r.hit | match;
  assign chain_out.pos = chain_r.hit ? chain_r.pos : mtf_pkg::MTF_POS_W'(IDX);
  assign entry         = entry_r;
  assign pre           = chain_r.hit;

endmodule

// File: sv/move_to_front_list_core.sv
// Move-to-front list core: row of entry cells with a rippling match token.
// A bounded move-to-front list of DEPTH signed 32-bit words held in a row of cells.
// An insert word (mode 0) lands at the front and every valid entry moves back one
// cell, or it is refused when the list is full. A find word (mode 1) latches its
// key and clears the match token; the token then moves one cell per clock down the
// row; at the end of the scan the matched entry moves to the front and the result
// is registered. The input stalls while a scan is running. The result sits in an
// output register; while it is held off by out_stall the input stalls as well, and
// a finished scan waits for that register to drain.
module move_to_front_list_core #(
  parameter int unsigned DEPTH = mtf_pkg::MTF_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_mode,
  input  logic signed [mtf_pkg::MTF_DATA_W-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_found,
  output logic [mtf_pkg::MTF_POS_OUT-1:0]       out_old_position,
  output logic                                  out_rejected,
  output logic [mtf_pkg::MTF_CNT_OUT-1:0]       out_entry_count
);

  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W = $clog2(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                               state_r, state_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [CW-1:0]                      fill_r, fill_nxt;
  logic [mtf_pkg::MTF_DATA_W-1:0]     key_r, key_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic                               found_r, found_nxt;
  logic [mtf_pkg::MTF_POS_OUT-1:0]    pos_r, pos_nxt;
  logic                               rej_r, rej_nxt;
  logic [mtf_pkg::MTF_CNT_OUT-1:0]    count_r, count_nxt;

  logic                               in_take;
  logic                               ins_go;
  logic                               fnd_go;
  logic                               clr;
  logic [mtf_pkg::MTF_DATA_W-1:0]     load_val;

  mtf_pkg::chain_t                    chain_out [DEPTH];
  logic [mtf_pkg::MTF_DATA_W-1:0]     entry     [DEPTH];
  logic [DEPTH-1:0]                   pre;
  logic [DEPTH-1:0]                   vld;
  mtf_pkg::chain_t                    last;

  assign last     = chain_out[DEPTH-1];
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign in_take  = in_valid && !in_stall;
  assign load_val = (state_r == S_IDLE) ? $unsigned(in_value) : key_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    fill_nxt      = fill_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r && out_stall;
    found_nxt     = found_r;
    pos_nxt       = pos_r;
    rej_nxt       = rej_r;
    count_nxt     = count_r;
    ins_go        = 1'b0;
    fnd_go        = 1'b0;
    clr           = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (!in_mode) begin
            out_valid_nxt = 1'b1;
            found_nxt     = 1'b0;
            pos_nxt       = '0;
            if (fill_r == CW'(DEPTH)) begin
              rej_nxt = 1'b1;
            end else begin
              rej_nxt  = 1'b0;
              ins_go   = 1'b1;
              fill_nxt = fill_r + CW'(1);
            end
            count_nxt = mtf_pkg::MTF_CNT_OUT'(fill_nxt);
          end else begin
            key_nxt   = $unsigned(in_value);
            clr       = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r == CNT_W'(DEPTH - 1)) begin
          if (!(out_valid_r && out_stall)) begin
            fnd_go        = last.hit;
            out_valid_nxt = 1'b1;
            found_nxt     = last.hit;
            pos_nxt       = last.hit ? last.pos[mtf_pkg::MTF_POS_OUT-1:0] : '0;
            rej_nxt       = 1'b0;
            count_nxt     = mtf_pkg::MTF_CNT_OUT'(fill_r);
            state_nxt     = S_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    rej_r   <= rej_nxt;
    count_r <= count_nxt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mtf_pkg::cell_ctl_t             ctl;
    mtf_pkg::chain_t                cin;
    logic [mtf_pkg::MTF_DATA_W-1:0] din;

    assign vld[i] = CW'(i) < fill_r;

    if (i == 0) begin : g_head
      assign cin    = '0;
      assign din    = load_val;
      assign ctl.ld = ins_go || fnd_go;
    end else begin : g_body
      assign cin    = chain_out[i-1];
      assign din    = entry[i-1];
      assign ctl.ld = (ins_go && vld[i-1]) || (fnd_go && !pre[i]);
    end
    assign ctl.clr = clr;

    mtf_cell #(
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .d_in      (din),
      .key       (key_r),
      .vld       (vld[i]),
      .chain_in  (cin),
      .chain_out (chain_out[i]),
      .entry     (entry[i]),
      .pre       (pre[i])
    );
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_old_position = pos_r;
  assign out_rejected     = rej_r;
  assign out_entry_count  = count_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_find_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_mode) |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("find word did not start a scan");

  a_found_not_rej: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(found_r && rej_r))
    else $error("result both found and rejected");

  a_rej_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rej_r) |-> (fill_r == CW'(DEPTH)))
    else $error("insert refused while list not full");
`endif

endmodule
